// ===== hw/rtl/mkdlp_pkg.sv =====
// Shared widths, reset values and register codes for the key debounce unit.
`default_nettype none

package mkdlp_pkg;

	// Fixed field widths of the channels and of the per-key counters.
	localparam int KEY_MASK_W = 6;
	localparam int PRESS_W    = 8;
	localparam int RELEASE_W  = 8;
	localparam int HOLD_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef logic [KEY_MASK_W-1:0] key_mask_t;
	typedef logic [PRESS_W-1:0]    press_cnt_t;
	typedef logic [RELEASE_W-1:0]  release_cnt_t;
	typedef logic [HOLD_W-1:0]     hold_cnt_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	// Configuration register indexes.
	localparam cfg_idx_t REG_PRESS_FILTER   = 2'd0;
	localparam cfg_idx_t REG_RELEASE_FILTER = 2'd1;
	localparam cfg_idx_t REG_LONG_TICKS     = 2'd2;

	// Register reset values.
	localparam press_cnt_t   RST_PRESS_FILTER   = 8'd2;
	localparam release_cnt_t RST_RELEASE_FILTER = 8'd10;
	localparam hold_cnt_t    RST_LONG_TICKS     = 16'd400;

endpackage

`default_nettype wire

// ===== hw/rtl/multi_key_debounce_long_press_unit.sv =====
// Multi-key debounce with long-press detection, top level.
//
// Usage: one input transfer per scan tick carries pressed_mask, one raw
// pressed bit per key. Every accepted transfer produces exactly one result
// transfer with key_events (the event flag of each key) and any_long_press.
// Both channels use valid/stall: a transfer happens on a rising edge where
// valid is high and stall is low. The input register takes the item at its
// transfer edge; the item moves on into the result register, which sets
// out_valid, as soon as that register is empty or being taken. One item
// can be taken in every cycle while the receiver does not stall, since
// each key's update is a short compare and increment between those two
// registers. When the receiver stalls, the result register holds;
// the input register still accepts one more item, and in_stall rises only
// while both registers are full and out_stall is high. Configuration is
// written through cfg_valid/cfg_ready/cfg_index/cfg_data (ready is always
// high) and must only be written while idle; an index beyond the register
// list is ignored. Reset loads the register reset values, empties both
// pipeline registers and clears the key state; release counts reset to 10.
`default_nettype none

module multi_key_debounce_long_press_unit #(
	parameter int NUM_KEYS = 6
) (
	input  wire                      clk,
	input  wire                      arst_n,
	// Input channel.
	input  wire                      in_valid,
	output logic                     in_stall,
	input  wire  mkdlp_pkg::key_mask_t pressed_mask,
	// Result channel.
	output logic                     out_valid,
	input  wire                      out_stall,
	output mkdlp_pkg::key_mask_t     key_events,
	output logic                     any_long_press,
	// Configuration write channel.
	input  wire                      cfg_valid,
	output logic                     cfg_ready,
	input  wire  mkdlp_pkg::cfg_idx_t  cfg_index,
	input  wire  mkdlp_pkg::cfg_data_t cfg_data
);
	import mkdlp_pkg::*;

	// Raw and event vectors are widened so that any key count fits; keys
	// beyond the mask width always read released.
	localparam int RAW_W = (NUM_KEYS > KEY_MASK_W) ? NUM_KEYS : KEY_MASK_W;

	// Configuration registers.
	press_cnt_t   press_filter_q;
	release_cnt_t release_filter_q;
	hold_cnt_t    long_ticks_q;

	// Input stage.
	logic      valid_s1;
	key_mask_t mask_s1;
	logic      advance;

	// Per-key state.
	press_cnt_t   press_cnt_q   [NUM_KEYS];
	release_cnt_t release_cnt_q [NUM_KEYS];
	hold_cnt_t    hold_cnt_q    [NUM_KEYS];
	logic [NUM_KEYS-1:0] down_q;
	logic [NUM_KEYS-1:0] event_q;
	logic [NUM_KEYS-1:0] long_q;

	// Next-state values.
	press_cnt_t   press_cnt_d   [NUM_KEYS];
	release_cnt_t release_cnt_d [NUM_KEYS];
	hold_cnt_t    hold_cnt_d    [NUM_KEYS];
	release_cnt_t release_min   [NUM_KEYS];
	hold_cnt_t    hold_inc      [NUM_KEYS];
	logic [NUM_KEYS-1:0] down_d;
	logic [NUM_KEYS-1:0] event_d;
	logic [NUM_KEYS-1:0] long_d;

	logic [RAW_W-1:0]    raw_wide;
	logic [NUM_KEYS-1:0] raw;
	logic [RAW_W-1:0]    event_wide;

	// Result register.
	logic      out_valid_q;
	key_mask_t key_events_q;
	logic      any_long_q;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_filter_q   <= RST_PRESS_FILTER;
			release_filter_q <= RST_RELEASE_FILTER;
			long_ticks_q     <= RST_LONG_TICKS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PRESS_FILTER:   press_filter_q   <= cfg_data[PRESS_W-1:0];
				REG_RELEASE_FILTER: release_filter_q <= cfg_data[RELEASE_W-1:0];
				REG_LONG_TICKS:     long_ticks_q     <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// The input register moves on whenever the result register is empty or
	// its contents are being taken this cycle.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mask_s1 <= pressed_mask;
		end
	end

	assign raw_wide = RAW_W'(mask_s1);
	assign raw      = raw_wide[NUM_KEYS-1:0];

	// Per-key filter and long-press update; every key is independent.
	always_comb begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			press_cnt_d[k]   = press_cnt_q[k];
			release_cnt_d[k] = release_cnt_q[k];
			hold_cnt_d[k]    = hold_cnt_q[k];
			down_d[k]        = down_q[k];
			event_d[k]       = event_q[k];
			long_d[k]        = long_q[k];
			hold_inc[k]      = hold_cnt_q[k] + hold_cnt_t'(1);
			release_min[k]   = (release_cnt_q[k] > release_filter_q) ?
				release_filter_q : release_cnt_q[k];

			if (raw[k]) begin
				if (press_cnt_q[k] > press_filter_q) begin
					// The filter was lowered below the running count.
					press_cnt_d[k] = '0;
				end else if (press_cnt_q[k] < press_filter_q) begin
					press_cnt_d[k] = press_cnt_q[k] + press_cnt_t'(1);
				end else begin
					if (!down_q[k]) begin
						down_d[k]        = 1'b1;
						release_cnt_d[k] = release_filter_q;
					end
					if (long_ticks_q != '0 && hold_cnt_q[k] < long_ticks_q) begin
						hold_cnt_d[k] = hold_inc[k];
						if (hold_inc[k] == long_ticks_q && !long_q[k]) begin
							long_d[k]  = 1'b1;
							event_d[k] = 1'b1;
						end
					end
				end
			end else begin
				press_cnt_d[k] = '0;
				hold_cnt_d[k]  = '0;
				if (release_min[k] != '0) begin
					release_cnt_d[k] = release_min[k] - release_cnt_t'(1);
					if (!down_q[k]) begin
						long_d[k]  = 1'b0;
						event_d[k] = 1'b0;
					end
				end else if (down_q[k]) begin
					// Confirmed release: a short press raises its event flag,
					// a long press clears both flags.
					release_cnt_d[k] = '0;
					down_d[k]        = 1'b0;
					event_d[k]       = !long_q[k];
					long_d[k]        = 1'b0;
				end else begin
					release_cnt_d[k] = '0;
					long_d[k]        = 1'b0;
					event_d[k]       = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				press_cnt_q[k]   <= '0;
				release_cnt_q[k] <= RST_RELEASE_FILTER;
				hold_cnt_q[k]    <= '0;
			end
			down_q  <= '0;
			event_q <= '0;
			long_q  <= '0;
		end else if (advance) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				press_cnt_q[k]   <= press_cnt_d[k];
				release_cnt_q[k] <= release_cnt_d[k];
				hold_cnt_q[k]    <= hold_cnt_d[k];
			end
			down_q  <= down_d;
			event_q <= event_d;
			long_q  <= long_d;
		end
	end

	assign event_wide = RAW_W'(event_d);

	// Result register: loaded with the state as it stands after the update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			key_events_q <= event_wide[KEY_MASK_W-1:0];
			any_long_q   <= |long_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign key_events     = key_events_q;
	assign any_long_press = any_long_q;

	// The input side only stalls while an item is waiting in the input stage.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input stage");

	// Every item that leaves the input stage lands in the result register.
	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed item did not reach the result register");

	// A long flag can only be held by a key that is confirmed down.
	a_long_implies_down: assert property (@(posedge clk) disable iff (!arst_n)
		(long_q & ~down_q) == '0)
		else $error("long flag set on a key that is not down");

	// Key state only changes when an item is processed.
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(down_q) && $stable(event_q) && $stable(long_q))
		else $error("key state changed without an item");

endmodule

`default_nettype wire
